// ===== design/gn3d_pkg.sv =====
// ----------------------------------------------------------------------------
// gn3d_pkg
// Shared constants, tables and helpers for the 3D gradient noise pipeline.
// ----------------------------------------------------------------------------
package gn3d_pkg;

  localparam int FracBits    = 16;
  localparam int OutFracBits = 15;
  localparam int CoordW      = 24;
  localparam int OutW        = 16;
  localparam int Scale097    = 63570;

  // Values with FracBits fraction bits, signed, wide enough for sums and blends.
  localparam int ValW = FracBits + 4;
  typedef logic signed [ValW-1:0] val_t;
  typedef logic [FracBits-1:0]    frac_t;
  typedef logic [7:0]             cell_t;

  localparam logic [7:0] PermRom [256] = '{
    8'd63, 8'd9, 8'd212, 8'd205, 8'd31, 8'd128, 8'd72, 8'd59, 8'd137, 8'd203,
    8'd195, 8'd170, 8'd181, 8'd115, 8'd165, 8'd40,
    8'd116, 8'd139, 8'd175, 8'd225, 8'd132, 8'd99, 8'd222, 8'd2, 8'd41, 8'd15,
    8'd197, 8'd93, 8'd169, 8'd90, 8'd228, 8'd43,
    8'd221, 8'd38, 8'd206, 8'd204, 8'd73, 8'd17, 8'd97, 8'd10, 8'd96, 8'd47,
    8'd32, 8'd138, 8'd136, 8'd30, 8'd219, 8'd78,
    8'd224, 8'd13, 8'd193, 8'd88, 8'd134, 8'd211, 8'd7, 8'd112, 8'd176, 8'd19,
    8'd106, 8'd83, 8'd75, 8'd217, 8'd85, 8'd0,
    8'd98, 8'd140, 8'd229, 8'd80, 8'd118, 8'd151, 8'd117, 8'd251, 8'd103, 8'd242,
    8'd81, 8'd238, 8'd172, 8'd82, 8'd110, 8'd4,
    8'd227, 8'd77, 8'd243, 8'd46, 8'd12, 8'd189, 8'd34, 8'd188, 8'd200, 8'd161,
    8'd68, 8'd76, 8'd171, 8'd194, 8'd57, 8'd48,
    8'd247, 8'd233, 8'd51, 8'd105, 8'd5, 8'd23, 8'd42, 8'd50, 8'd216, 8'd45,
    8'd239, 8'd148, 8'd249, 8'd84, 8'd70, 8'd125,
    8'd108, 8'd241, 8'd62, 8'd66, 8'd64, 8'd240, 8'd173, 8'd185, 8'd250, 8'd49,
    8'd6, 8'd37, 8'd26, 8'd21, 8'd244, 8'd60,
    8'd223, 8'd255, 8'd16, 8'd145, 8'd27, 8'd109, 8'd58, 8'd102, 8'd142, 8'd253,
    8'd120, 8'd149, 8'd160, 8'd124, 8'd156, 8'd79,
    8'd186, 8'd135, 8'd127, 8'd14, 8'd121, 8'd22, 8'd65, 8'd54, 8'd153, 8'd91,
    8'd213, 8'd174, 8'd24, 8'd252, 8'd131, 8'd192,
    8'd190, 8'd202, 8'd208, 8'd35, 8'd94, 8'd231, 8'd56, 8'd95, 8'd183, 8'd163,
    8'd111, 8'd147, 8'd25, 8'd67, 8'd36, 8'd92,
    8'd236, 8'd71, 8'd166, 8'd1, 8'd187, 8'd100, 8'd130, 8'd143, 8'd237, 8'd178,
    8'd158, 8'd104, 8'd184, 8'd159, 8'd177, 8'd52,
    8'd214, 8'd230, 8'd119, 8'd87, 8'd114, 8'd201, 8'd179, 8'd198, 8'd3, 8'd248,
    8'd182, 8'd39, 8'd11, 8'd152, 8'd196, 8'd113,
    8'd20, 8'd232, 8'd69, 8'd141, 8'd207, 8'd234, 8'd53, 8'd86, 8'd180, 8'd226,
    8'd74, 8'd150, 8'd218, 8'd29, 8'd133, 8'd8,
    8'd44, 8'd123, 8'd28, 8'd146, 8'd89, 8'd101, 8'd154, 8'd220, 8'd126, 8'd155,
    8'd122, 8'd210, 8'd168, 8'd254, 8'd162, 8'd129,
    8'd33, 8'd18, 8'd209, 8'd61, 8'd191, 8'd199, 8'd157, 8'd245, 8'd55, 8'd164,
    8'd167, 8'd215, 8'd246, 8'd144, 8'd107, 8'd235
  };

  function automatic cell_t hash8(input cell_t i);
    hash8 = PermRom[i];
  endfunction

  // Gradient dot product: per code, a signed sum of two of x, y, z.
  function automatic val_t grad(input logic [3:0] h, input val_t x, input val_t y,
                                input val_t z);
    case (h)
      4'd0:    grad = x + z;
      4'd1:    grad = x + y;
      4'd2:    grad = y + z;
      4'd3:    grad = y - x;
      4'd4:    grad = z - x;
      4'd5:    grad = -x - y;
      4'd6:    grad = z - y;
      4'd7:    grad = x - y;
      4'd8:    grad = x - z;
      4'd9:    grad = y - z;
      4'd10:   grad = -x - z;
      4'd11:   grad = -y - z;
      4'd12:   grad = x + y;
      4'd13:   grad = y - x;
      4'd14:   grad = z - y;
      default: grad = -y - z;
    endcase
  endfunction

  // Round to nearest, ties up: floor((p + half) >> FracBits).
  localparam int ProdW = 2 * ValW;
  function automatic val_t rnd_shift(input logic signed [ProdW-1:0] p);
    logic signed [ProdW-1:0] n;
    n = p + (ProdW'(1) <<< (FracBits - 1));
    rnd_shift = val_t'(n >>> FracBits);
  endfunction

endpackage

// ===== design/gn3d_fade.sv =====
// ----------------------------------------------------------------------------
// gn3d_fade
// Quintic fade 6t^5-15t^4+10t^3 in three registered stages with stall enable.
// ----------------------------------------------------------------------------
module gn3d_fade (
  input  logic             clk_i,
  input  logic             en_i,
  input  gn3d_pkg::frac_t  f_i,
  output gn3d_pkg::val_t   s_o
);
  import gn3d_pkg::*;

  localparam int F2W = FracBits;
  logic [F2W-1:0]      f2_q, f_a_q, f3_q;
  logic [FracBits+4:0] t_q;
  logic [2*F2W-1:0]    p2, p3;
  logic [FracBits+4:0] t_d;
  logic [2*FracBits+4:0] p4;
  val_t s_q;

  assign p2 = f_i * f_i;
  assign p3 = f2_q * f_a_q;
  assign t_d = (FracBits+5)'(6) * (FracBits+5)'(f2_q) + ((FracBits+5)'(10) << FracBits)
             - (FracBits+5)'(15) * (FracBits+5)'(f_a_q);
  assign p4 = f3_q * t_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      f2_q  <= p2[2*FracBits-1:FracBits];
      f_a_q <= f_i;
      f3_q  <= p3[2*FracBits-1:FracBits];
      t_q   <= t_d;
      s_q   <= val_t'(p4 >> FracBits);
    end
  end

  assign s_o = s_q;
endmodule

// ===== design/gn3d_hash.sv =====
// ----------------------------------------------------------------------------
// gn3d_hash
// Lattice corner hashing through the permutation ROM, three stages, then
// gradient dot products (one more stage). Four registered stages total.
// ----------------------------------------------------------------------------
module gn3d_hash (
  input  logic            clk_i,
  input  logic            en_i,
  input  gn3d_pkg::cell_t xi_i,
  input  gn3d_pkg::cell_t yi_i,
  input  gn3d_pkg::cell_t zi_i,
  input  gn3d_pkg::frac_t fx_i,
  input  gn3d_pkg::frac_t fy_i,
  input  gn3d_pkg::frac_t fz_i,
  output gn3d_pkg::val_t  n_o [8]
);
  import gn3d_pkg::*;

  cell_t a_q, b_q, zi1_q, aa_q, ab_q, ba_q, bb_q;
  frac_t fx1_q, fy1_q, fz1_q, fx2_q, fy2_q, fz2_q, fx3_q, fy3_q, fz3_q;
  logic [3:0] h_q [8];
  val_t n_q [8];
  val_t x0, y0, z0, x1, y1, z1;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_q   <= hash8(xi_i) + yi_i;
      b_q   <= hash8(xi_i + 8'd1) + yi_i;
      zi1_q <= zi_i;
      fx1_q <= fx_i; fy1_q <= fy_i; fz1_q <= fz_i;
      aa_q  <= hash8(a_q) + zi1_q;
      ab_q  <= hash8(a_q + 8'd1) + zi1_q;
      ba_q  <= hash8(b_q) + zi1_q;
      bb_q  <= hash8(b_q + 8'd1) + zi1_q;
      fx2_q <= fx1_q; fy2_q <= fy1_q; fz2_q <= fz1_q;
      h_q[0] <= 4'(hash8(aa_q));
      h_q[1] <= 4'(hash8(ba_q));
      h_q[2] <= 4'(hash8(ab_q));
      h_q[3] <= 4'(hash8(bb_q));
      h_q[4] <= 4'(hash8(aa_q + 8'd1));
      h_q[5] <= 4'(hash8(ba_q + 8'd1));
      h_q[6] <= 4'(hash8(ab_q + 8'd1));
      h_q[7] <= 4'(hash8(bb_q + 8'd1));
      fx3_q <= fx2_q; fy3_q <= fy2_q; fz3_q <= fz2_q;
      for (int i = 0; i < 8; i++) begin
        n_q[i] <= grad(h_q[i], i[0] ? x1 : x0, i[1] ? y1 : y0, i[2] ? z1 : z0);
      end
    end
  end

  assign x0 = val_t'(fx3_q);
  assign y0 = val_t'(fy3_q);
  assign z0 = val_t'(fz3_q);
  assign x1 = x0 - (val_t'(1) <<< FracBits);
  assign y1 = y0 - (val_t'(1) <<< FracBits);
  assign z1 = z0 - (val_t'(1) <<< FracBits);

  assign n_o = n_q;
endmodule

// ===== design/gn3d_blend.sv =====
// ----------------------------------------------------------------------------
// gn3d_blend
// Trilinear blend (lerps along x, then y, then z), 0.97 scaling and saturation.
// Each multiply is registered before its rounding add.
// ----------------------------------------------------------------------------
module gn3d_blend (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  gn3d_pkg::val_t                n_i [8],
  input  gn3d_pkg::val_t                u_i,
  input  gn3d_pkg::val_t                v_i,
  input  gn3d_pkg::val_t                w_i,
  output logic signed [gn3d_pkg::OutW-1:0] y_o
);
  import gn3d_pkg::*;

  localparam int Sh = 16 + FracBits - OutFracBits;
  localparam int SW = ProdW;

  // stage A: products for the x blend
  logic signed [ProdW-1:0] px_q [4];
  val_t ax_q [4], v1_q, w1_q;
  val_t l_q [4], v2_q, w2_q;
  logic signed [ProdW-1:0] py_q [2];
  val_t ay_q [2], w3_q;
  val_t m_q [2], w4_q;
  logic signed [ProdW-1:0] pz_q;
  val_t az_q;
  val_t r_q;
  logic signed [SW-1:0] ps_q;
  logic signed [OutW-1:0] y_q;
  logic signed [SW-1:0] s_r, hi, lo;

  assign hi = (SW'(1) <<< OutFracBits) - SW'(1);
  assign lo = -(SW'(1) <<< OutFracBits);
  generate
    if (Sh > 0) begin : g_rs
      assign s_r = (ps_q + (SW'(1) <<< (Sh - 1))) >>> Sh;
    end else begin : g_ls
      assign s_r = ps_q <<< (-Sh);
    end
  endgenerate

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 4; i++) begin
        px_q[i] <= ProdW'(n_i[2*i+1] - n_i[2*i]) * ProdW'(u_i);
        ax_q[i] <= n_i[2*i];
        l_q[i]  <= ax_q[i] + rnd_shift(px_q[i]);
      end
      v1_q <= v_i; w1_q <= w_i;
      v2_q <= v1_q; w2_q <= w1_q;
      for (int j = 0; j < 2; j++) begin
        py_q[j] <= ProdW'(l_q[2*j+1] - l_q[2*j]) * ProdW'(v2_q);
        ay_q[j] <= l_q[2*j];
        m_q[j]  <= ay_q[j] + rnd_shift(py_q[j]);
      end
      w3_q <= w2_q;
      w4_q <= w3_q;
      pz_q <= ProdW'(m_q[1] - m_q[0]) * ProdW'(w4_q);
      az_q <= m_q[0];
      r_q  <= az_q + rnd_shift(pz_q);
      ps_q <= SW'(r_q) * SW'(Scale097);
      if (s_r > hi) y_q <= OutW'(hi);
      else if (s_r < lo) y_q <= OutW'(lo);
      else y_q <= OutW'(s_r);
    end
  end

  assign y_o = y_q;
endmodule

// ===== design/gradient_noise_3d_core.sv =====
// ----------------------------------------------------------------------------
// gradient_noise_3d_core
// 3D gradient noise, one point per cycle unless stalled, deep pipeline.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: coord_x_i/y_i/z_i (unsigned Q8.16) with in_valid_i and
//   in_ready_o; a word is taken when both are high. Output channel:
//   noise_value_o (signed Q1.15, noise * 0.97, saturated) with out_valid_o
//   and out_ready_i.
//   Pipeline: 12 register stages (4 hash/gradient stages, fade runs
//   alongside, 8 blend/scale/saturate stages).
//   Throughput: one word per cycle unless stalled, fully pipelined datapath.
//   A valid bit travels with each stage. When the receiver stalls with a
//   word waiting at the output, the whole pipeline holds (a shared enable);
//   bubbles are squeezed out as long as the output slot is free, so
//   in_ready_o = !out_valid_o || out_ready_i.
//   Reset clears all valid bits; payload registers are not reset.
// ----------------------------------------------------------------------------
module gradient_noise_3d_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [gn3d_pkg::CoordW-1:0]        coord_x_i,
  input  logic [gn3d_pkg::CoordW-1:0]        coord_y_i,
  input  logic [gn3d_pkg::CoordW-1:0]        coord_z_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [gn3d_pkg::OutW-1:0]   noise_value_o
);
  import gn3d_pkg::*;

  localparam int Lat = 12;

  logic [Lat-1:0] vld_q;
  logic en;
  val_t n [8];
  val_t u, v, w;
  val_t u_d1_q, v_d1_q, w_d1_q;

  // global advance: the last stage is free or being drained
  assign en = !vld_q[Lat-1] || out_ready_i;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Lat-2:0], in_valid_i};
    end
  end

  gn3d_hash u_hash (
    .clk_i, .en_i(en),
    .xi_i(coord_x_i[FracBits +: 8]), .yi_i(coord_y_i[FracBits +: 8]),
    .zi_i(coord_z_i[FracBits +: 8]),
    .fx_i(coord_x_i[FracBits-1:0]), .fy_i(coord_y_i[FracBits-1:0]),
    .fz_i(coord_z_i[FracBits-1:0]),
    .n_o(n)
  );

  // fades take three stages; one more aligns them with the gradients
  gn3d_fade u_fx (.clk_i, .en_i(en), .f_i(coord_x_i[FracBits-1:0]), .s_o(u));
  gn3d_fade u_fy (.clk_i, .en_i(en), .f_i(coord_y_i[FracBits-1:0]), .s_o(v));
  gn3d_fade u_fz (.clk_i, .en_i(en), .f_i(coord_z_i[FracBits-1:0]), .s_o(w));

  always_ff @(posedge clk_i) begin
    if (en) begin
      u_d1_q <= u; v_d1_q <= v; w_d1_q <= w;
    end
  end

  gn3d_blend u_blend (
    .clk_i, .en_i(en), .n_i(n),
    .u_i(u_d1_q), .v_i(v_d1_q), .w_i(w_d1_q),
    .y_o(noise_value_o)
  );

  assign out_valid_o = vld_q[Lat-1];
endmodule

// ===== design/gn3d_checker.sv =====
// ----------------------------------------------------------------------------
// gn3d_checker
// Port-level checks on the noise core, bound to the top level.
// ----------------------------------------------------------------------------
module gn3d_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             in_valid_i,
  input logic                             in_ready_o,
  input logic                             out_valid_o,
  input logic                             out_ready_i,
  input logic signed [gn3d_pkg::OutW-1:0] noise_value_o
);
  import gn3d_pkg::*;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(noise_value_o))
    else $error("output word dropped or changed under stall");

  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty output");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> noise_value_o <= OutW'((1 << OutFracBits) - 1))
    else $error("noise above saturation limit");
endmodule

bind gradient_noise_3d_core gn3d_checker u_gn3d_checker (.*);

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks gradient_noise_3d_core against a fixed-point noise predictor: directed
// corner points, then random points under random idling and backpressure.
// ----------------------------------------------------------------------------
module testbench;
  import gn3d_pkg::*;

  localparam int Latency   = 12;
  localparam int WatchdogN = 20000;

  // Gradient code table: coefficient of x, y, z per code.
  localparam int GradX [16] = '{1, 1, 0, -1, -1, -1, 0, 1, 1, 0, -1, 0, 1, -1, 0, 0};
  localparam int GradY [16] = '{0, 1, 1, 1, 0, -1, -1, -1, 0, 1, 0, -1, 1, 1, -1, -1};
  localparam int GradZ [16] = '{1, 0, 1, 0, 1, 0, 1, 0, -1, -1, -1, -1, 0, 0, 1, -1};

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [CoordW-1:0]  coord_x_i;
  logic [CoordW-1:0]  coord_y_i;
  logic [CoordW-1:0]  coord_z_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic signed [OutW-1:0] noise_value_o;

  gradient_noise_3d_core dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .coord_x_i    (coord_x_i),
    .coord_y_i    (coord_y_i),
    .coord_z_i    (coord_z_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .noise_value_o(noise_value_o)
  );

  // expected noise words, oldest first
  logic signed [OutW-1:0] noise_q[$];
  int   n_errors;
  int   idle_cycles;
  bit   rx_hold;        // long receiver hold-off requested
  bit   rx_no_idle;     // stretch with no random stalls
  bit   tx_no_idle;

  always begin
    clk_i = 1'b1; #5;
    clk_i = 1'b0; #5;
  end

  // ---------------------------------------------------------------- predictor
  function automatic logic [7:0] perm(input int i);
    return PermRom[i & 255];
  endfunction

  // round to nearest, ties toward +inf: floor((p + 2^(sh-1)) / 2^sh)
  function automatic longint round_shift(input longint p, input int sh);
    return (p + (longint'(1) << (sh - 1))) >>> sh;
  endfunction

  function automatic longint quintic(input longint f);
    longint f2, f3, t;
    f2 = (f * f) >>> FracBits;
    f3 = (f2 * f) >>> FracBits;
    t  = 6 * f2 + (longint'(10) << FracBits) - 15 * f;
    return (f3 * t) >>> FracBits;
  endfunction

  function automatic longint corner_dot(input int h, input longint x, input longint y,
                                        input longint z);
    return GradX[h & 15] * x + GradY[h & 15] * y + GradZ[h & 15] * z;
  endfunction

  function automatic longint blend(input longint a, input longint b, input longint w);
    return a + round_shift((b - a) * w, FracBits);
  endfunction

  function automatic logic signed [OutW-1:0] noise_at(input logic [CoordW-1:0] cx,
                                                      input logic [CoordW-1:0] cy,
                                                      input logic [CoordW-1:0] cz);
    int xi, yi, zi, a, aa, ab, b, ba, bb;
    longint x, y, z, x1, y1, z1, u, v, w, one;
    longint l1, l2, l3, l4, m1, m2, r, s;
    one = longint'(1) << FracBits;
    xi = cx[CoordW-1:FracBits]; yi = cy[CoordW-1:FracBits]; zi = cz[CoordW-1:FracBits];
    x = cx[FracBits-1:0]; y = cy[FracBits-1:0]; z = cz[FracBits-1:0];
    x1 = x - one; y1 = y - one; z1 = z - one;
    a  = perm(xi) + yi;
    aa = perm(a) + zi;
    ab = perm(a + 1) + zi;
    b  = perm(xi + 1) + yi;
    ba = perm(b) + zi;
    bb = perm(b + 1) + zi;
    u = quintic(x); v = quintic(y); w = quintic(z);
    l1 = blend(corner_dot(perm(aa), x, y, z), corner_dot(perm(ba), x1, y, z), u);
    l2 = blend(corner_dot(perm(ab), x, y1, z), corner_dot(perm(bb), x1, y1, z), u);
    l3 = blend(corner_dot(perm(aa + 1), x, y, z1), corner_dot(perm(ba + 1), x1, y, z1), u);
    l4 = blend(corner_dot(perm(ab + 1), x, y1, z1), corner_dot(perm(bb + 1), x1, y1, z1), u);
    m1 = blend(l1, l2, v);
    m2 = blend(l3, l4, v);
    r  = blend(m1, m2, w);
    s  = round_shift(r * Scale097, 16 + FracBits - OutFracBits);
    if (s > (longint'(1) << OutFracBits) - 1) s = (longint'(1) << OutFracBits) - 1;
    if (s < -(longint'(1) << OutFracBits)) s = -(longint'(1) << OutFracBits);
    return OutW'(s);
  endfunction

  // ---------------------------------------------------------------- checking
  task automatic report_mismatch(input string msg);
    $display("ERROR %0t: %s", $realtime, msg);
    n_errors++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (noise_q.size() == 0) begin
        report_mismatch($sformatf("unexpected word noise_value=%0d", noise_value_o));
      end else begin
        if (noise_value_o !== noise_q[0])
          report_mismatch($sformatf("noise_value got %0d want %0d",
                                    noise_value_o, noise_q[0]));
        void'(noise_q.pop_front());
      end
    end
  end

  // receiver: random stalls, a quiet stretch, and an optional long hold-off
  always @(negedge clk_i) begin
    if (!rst_ni) out_ready_i <= 1'b0;
    else if (rx_hold) out_ready_i <= 1'b0;
    else if (rx_no_idle) out_ready_i <= 1'b1;
    else out_ready_i <= ($urandom_range(99) >= 15);
  end

  // watchdog on cycles with no accepted word
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogN) begin
      $display("FAIL gradient_noise_3d_core");
      $finish;
    end
  end

  // ---------------------------------------------------------------- stimulus
  // Send one point; the word is accepted at the rising edge with ready high.
  // Valid is left high on return; idle gaps and the callers drop it.
  task automatic send_point(input logic [CoordW-1:0] x, input logic [CoordW-1:0] y,
                            input logic [CoordW-1:0] z);
    while (!tx_no_idle && $urandom_range(99) < 15) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    coord_x_i  <= x;
    coord_y_i  <= y;
    coord_z_i  <= z;
    do @(posedge clk_i); while (!in_ready_o);
    noise_q.push_back(noise_at(x, y, z));
    @(negedge clk_i);
  endtask

  // Fields at their extremes, lattice points and cell wrap.
  task automatic test_corners();
    send_point('0, '0, '0);
    send_point('1, '1, '1);
    send_point(24'hFF_0000, 24'h00_FFFF, 24'hFF_8000);
    send_point(24'h00_8000, 24'h00_8000, 24'h00_8000);
    send_point(24'hFF_FFFF, 24'h00_0000, 24'hAA_5555);
    send_point(24'h00_0001, 24'hFF_FFFE, 24'h80_0001);
    for (int i = 0; i < 16; i++)
      send_point({8'(i), 16'h4000}, {8'(i * 17), 16'hC000}, {8'(255 - i), 16'h8000});
  endtask

  function automatic logic [CoordW-1:0] rand_coord();
    case ($urandom_range(7))
      0: return {8'($urandom), 16'h0000};
      1: return {8'($urandom), 16'hFFFF};
      default: return CoordW'($urandom);
    endcase
  endfunction

  task automatic test_random(input int n);
    repeat (n) send_point(rand_coord(), rand_coord(), rand_coord());
  endtask

  // Receiver holds off while the sender keeps offering, so the pipe fills.
  task automatic test_backpressure();
    fork
      begin
        rx_hold = 1'b1;
        repeat (60) @(posedge clk_i);
        rx_hold = 1'b0;
      end
      test_random(40);
    join
  endtask

  // Sender pauses until every word is back, then streams with no idling.
  task automatic test_drain_and_stream();
    in_valid_i <= 1'b0;
    wait (noise_q.size() == 0);
    tx_no_idle = 1'b1;
    rx_no_idle = 1'b1;
    test_random(150);
    tx_no_idle = 1'b0;
    rx_no_idle = 1'b0;
  endtask

  initial begin
    n_errors    = 0;
    idle_cycles = 0;
    rx_hold     = 1'b0;
    rx_no_idle  = 1'b0;
    tx_no_idle  = 1'b0;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    out_ready_i = 1'b0;
    coord_x_i   = '0;
    coord_y_i   = '0;
    coord_z_i   = '0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;

    test_corners();
    test_random(200);
    test_backpressure();
    test_drain_and_stream();
    test_random(200);

    in_valid_i <= 1'b0;
    wait (noise_q.size() == 0);
    repeat (Latency + 5) @(posedge clk_i);
    if (n_errors == 0) $display("PASS gradient_noise_3d_core");
    else $display("FAIL gradient_noise_3d_core");
    $finish;
  end

endmodule
